// ===== design/wsc_pkg.sv =====
package wsc_pkg;

  // Default sizing of the frame table
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 20;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths
  localparam int WINDOW_W  = 16;
  localparam int OUT_IDX_W = 3;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_TAKE
  } wsc_state_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic page_eq;
    logic aged;
  } wsc_cmp_res_t;

endpackage

// ===== design/wsc_mem.sv =====
module wsc_mem import wsc_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int IDX_W    = $clog2(FRAMES)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  logic [PAGE_BITS-1:0] wpage,
  input  logic [TIME_BITS-1:0] wtime,
  input  logic [IDX_W-1:0]     raddr,
  output logic [PAGE_BITS-1:0] rpage,
  output logic [TIME_BITS-1:0] rtime
);

  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [TIME_BITS-1:0] time_mem [FRAMES];

  always_ff @(posedge clk) begin
    if (we) begin
      page_mem[waddr] <= wpage;
      time_mem[waddr] <= wtime;
    end
  end

  // Registered read: data shows up in the cycle after the address
  always_ff @(posedge clk) begin
    rpage <= page_mem[raddr];
    rtime <= time_mem[raddr];
  end

endmodule

// ===== design/wsc_cmp.sv =====
module wsc_cmp import wsc_pkg::*; #(
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [PAGE_BITS-1:0] key_page,
  input  logic [PAGE_BITS-1:0] entry_page,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] last_use,
  input  logic [WINDOW_W-1:0]  window,
  output wsc_cmp_res_t         res
);

  localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

  logic [TIME_BITS-1:0] age;

  // Modular age, then compare at the wider of the two widths
  assign age         = now - last_use;
  assign res.page_eq = (key_page == entry_page);
  assign res.aged    = (CMP_W'(age) > CMP_W'(window));

endmodule

// ===== design/wsclock_page_replacement.sv =====
// A reference is looked up frame by frame from frame 0, and a hit ends the lookup at that frame. A
// miss then scans from the hand for a free or aged, unreferenced frame, or takes the hand's frame.
// busy stays high until a reference is done, so a new one is taken only after the last one; the
// one-read-per-cycle frame store and the shared compare unit set the pace.
// Reset (rst_n low, synchronous) empties all frames and zeroes the hand and the time counter.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module wsclock_page_replacement import wsc_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Reference input
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] in_page,
  // Result output
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [OUT_IDX_W-1:0] out_frame_index,
  output logic                 out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [OUT_IDX_W-1:0] out_hand_after,
  // Window register write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [WINDOW_W-1:0]  cfg_time_window
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

  wsc_state_t state_r, state_nxt;

  logic [IDX_W-1:0]     idx_r, idx_nxt;     // frame whose data is on the read port
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;     // frames passed over in this scan
  logic [IDX_W-1:0]     hand_r;
  logic [TIME_BITS-1:0] time_r;
  logic [WINDOW_W-1:0]  window_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [FRAMES-1:0]    valid_r;
  logic [FRAMES-1:0]    ref_r;

  logic [PAGE_BITS-1:0] rd_page;
  logic [TIME_BITS-1:0] rd_time;
  wsc_cmp_res_t         cmp;

  logic                 accept;
  logic                 found;
  logic                 free_slot;
  logic                 last;
  logic                 lap_done;
  logic [IDX_W-1:0]     next_idx;

  logic                 mem_we;
  logic                 done;
  logic                 is_hit;
  logic                 clr_ref;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [OUT_IDX_W-1:0] out_frame_index_r;
  logic                 out_evicted_valid_r;
  logic [PAGE_BITS-1:0] out_evicted_page_r;
  logic [OUT_IDX_W-1:0] out_hand_after_r;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Frame store: page and last-use time, read one frame per cycle
  wsc_mem #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r),
    .wpage (page_r),
    .wtime (time_r),
    .raddr (idx_nxt),
    .rpage (rd_page),
    .rtime (rd_time)
  );

  // Shared compare unit: page match during lookup, age test during the scan
  wsc_cmp #(
    .PAGE_BITS (PAGE_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .key_page   (page_r),
    .entry_page (rd_page),
    .now        (time_r),
    .last_use   (rd_time),
    .window     (window_r),
    .res        (cmp)
  );

  // Decisions on the frame currently read
  assign found     = valid_r[idx_r] && cmp.page_eq;
  assign free_slot = !valid_r[idx_r] || (!ref_r[idx_r] && cmp.aged);
  assign last      = (idx_r == LAST_IDX);
  assign lap_done  = (cnt_r == LAST_IDX);
  assign next_idx  = last ? '0 : idx_r + 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (found) state_nxt = ST_IDLE;
        else if (last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (free_slot) state_nxt = ST_IDLE;
        else if (lap_done) state_nxt = ST_TAKE;
      end
      ST_TAKE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    mem_we  = 1'b0;
    done    = 1'b0;
    is_hit  = 1'b0;
    clr_ref = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // Keep frame 0 on the read port so lookup starts right after the transfer
        idx_nxt = '0;
      end
      ST_LOOKUP: begin
        if (found) begin
          mem_we = 1'b1;
          done   = 1'b1;
          is_hit = 1'b1;
        end else if (last) begin
          idx_nxt = hand_r;
          cnt_nxt = '0;
        end else begin
          idx_nxt = next_idx;
        end
      end
      ST_SCAN: begin
        if (free_slot) begin
          mem_we = 1'b1;
          done   = 1'b1;
        end else begin
          // Pass over: drop the reference bit, advance; after a full lap return to the hand
          clr_ref = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          idx_nxt = lap_done ? hand_r : next_idx;
        end
      end
      ST_TAKE: begin
        mem_we = 1'b1;
        done   = 1'b1;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      cnt_r    <= '0;
      hand_r   <= '0;
      time_r   <= '0;
      window_r <= WINDOW_RESET;
      valid_r  <= '0;
      ref_r    <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_time_window;
      end
      if (clr_ref) begin
        ref_r[idx_r] <= 1'b0;
      end
      if (mem_we) begin
        valid_r[idx_r] <= 1'b1;
        ref_r[idx_r]   <= 1'b1;
      end
      if (done) begin
        time_r <= time_r + 1'b1;
        if (!is_hit) hand_r <= next_idx;
      end
    end
  end

  // Hold the referenced page for the whole item
  always_ff @(posedge clk) begin
    if (accept) page_r <= in_page;
  end

  // Result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_hit_r           <= is_hit;
      out_frame_index_r   <= OUT_IDX_W'(idx_r);
      out_evicted_valid_r <= !is_hit && valid_r[idx_r];
      out_evicted_page_r  <= (!is_hit && valid_r[idx_r]) ? rd_page : '0;
      out_hand_after_r    <= is_hit ? OUT_IDX_W'(hand_r) : OUT_IDX_W'(next_idx);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_hand_after    = out_hand_after_r;

`ifndef SYNTHESIS
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("still busy while a result is shown");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evicted_valid)
    else $error("hit reported an eviction");

  a_start_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_LOOKUP && idx_r == '0))
    else $error("transfer did not begin lookup at frame zero");
`endif

endmodule

// ===== tb/tb_wsclock_page_replacement.sv =====
module tb_wsclock_page_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  import wsc_pkg::*;

  // Cycles without any transfer before the run is declared hung. The slowest
  // item is the longest sender gap plus a full miss scan.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 220;

  typedef logic [PAGE_BITS_DEF-1:0] page_t;

  // One expected result, tagged with the page that caused it for reporting.
  typedef struct packed {
    page_t                page;
    logic                 hit;
    logic [OUT_IDX_W-1:0] frame_index;
    logic                 evicted_valid;
    page_t                evicted_page;
    logic [OUT_IDX_W-1:0] hand_after;
  } ref_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 start = 1'b0;
  logic                 busy;
  page_t                in_page = '0;
  logic                 out_valid;
  logic                 out_hit;
  logic [OUT_IDX_W-1:0] out_frame_index;
  logic                 out_evicted_valid;
  page_t                out_evicted_page;
  logic [OUT_IDX_W-1:0] out_hand_after;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WINDOW_W-1:0]  cfg_time_window = '0;

  // Frame table mirror: what the block should hold after every accepted reference.
  bit                       resident [FRAMES_DEF] = '{default: 1'b0};
  page_t                    frame_pg [FRAMES_DEF] = '{default: '0};
  bit                       ref_bit  [FRAMES_DEF] = '{default: 1'b0};
  logic [TIME_BITS_DEF-1:0] last_use [FRAMES_DEF] = '{default: '0};
  int                       hand = 0;
  logic [TIME_BITS_DEF-1:0] ref_clock = '0;
  logic [WINDOW_W-1:0]      window = WINDOW_RESET;

  ref_result_t expected_results [$];
  int          fail_count = 0;
  int          max_gap = 18;
  int          idle_cycles = 0;

  always #1 clk = ~clk;

  wsclock_page_replacement DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page          (in_page),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_frame_index  (out_frame_index),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_hand_after   (out_hand_after),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_time_window  (cfg_time_window)
  );

  // Count every failure; print only the first ten.
  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endfunction

  // Apply one page reference to the mirrored frame table and return the
  // result the block must produce for it.
  function automatic ref_result_t predict_reference(input page_t pg);
    ref_result_t              r;
    int                       i;
    int                       slot;
    int                       pos;
    bit                       done;
    logic [TIME_BITS_DEF-1:0] age;
    r = '0;
    r.page = pg;
    slot = -1;
    // Hit: take the lowest valid frame that holds the page.
    for (i = 0; i < FRAMES_DEF; i++)
      if (slot < 0 && resident[i] && frame_pg[i] == pg) slot = i;
    if (slot >= 0) begin
      r.hit = 1'b1;
      ref_bit[slot] = 1'b1;
      last_use[slot] = ref_clock;
    end else begin
      // Miss: sweep from the hand, clearing the bit of every frame passed over.
      // A full circle lands back on the starting frame, which is then taken.
      pos = hand;
      done = 1'b0;
      for (i = 0; i < FRAMES_DEF && !done; i++) begin
        age = ref_clock - last_use[pos];
        if (!resident[pos] || (!ref_bit[pos] && age > window)) begin
          done = 1'b1;
        end else begin
          ref_bit[pos] = 1'b0;
          pos = (pos + 1) % FRAMES_DEF;
        end
      end
      slot = pos;
      r.evicted_valid = resident[slot];
      r.evicted_page = resident[slot] ? frame_pg[slot] : '0;
      hand = (slot + 1) % FRAMES_DEF;
      resident[slot] = 1'b1;
      frame_pg[slot] = pg;
      ref_bit[slot] = 1'b1;
      last_use[slot] = ref_clock;
    end
    ref_clock = ref_clock + 1'b1;
    r.frame_index = slot[OUT_IDX_W-1:0];
    r.hand_after = hand[OUT_IDX_W-1:0];
    return r;
  endfunction

  // Send one reference: hold off a random gap, raise start, wait for the
  // transfer, then log its expected result. Keep start high when the gap is
  // zero so back-to-back items never see it dropped and raised in one step.
  task automatic send_reference(input page_t pg);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_page <= pg;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_reference(pg));
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write the window register once the block has gone quiet.
  task automatic write_window(input logic [WINDOW_W-1:0] w);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_time_window <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window = w;
  endtask

  // Fill the empty table at the reset window; pages cover the field extremes.
  task automatic test_cold_fill();
    send_reference('0);
    send_reference('1);
    send_reference(20'hAAAAA);
    send_reference(20'h55555);
    send_reference(20'h00001);
    send_reference(20'h00002);
    send_reference(20'h80000);
    send_reference(20'h7FFFF);
  endtask

  // Re-reference resident pages: no eviction and the hand stays put.
  task automatic test_hits();
    send_reference('1);
    send_reference('0);
    send_reference(20'h7FFFF);
  endtask

  // Every frame is referenced now, so the first miss sweeps a full circle and
  // takes the frame at the hand; the next one finds an aged frame.
  task automatic test_full_circle();
    send_reference(20'h12345);
    send_reference(20'h23456);
  endtask

  // Widest window: nothing ages out, misses keep circling. Narrowest window:
  // any unreferenced frame older than zero references goes.
  task automatic test_window_extremes();
    write_window('1);
    send_reference(20'h34567);
    send_reference(20'h45678);
    send_reference(20'h56789);
    write_window('0);
    send_reference(20'h6789A);
    send_reference(20'h789AB);
    send_reference(20'h56789);
    send_reference(20'h89ABC);
  endtask

  // Working-set traffic: each phase draws a window and a pool of pages and
  // mostly references the pool, with stray pages and pool churn mixed in.
  task automatic test_random_traffic();
    page_t               pool [16];
    int                  pool_size;
    int                  ph;
    int                  n;
    int                  k;
    int                  roll;
    logic [WINDOW_W-1:0] w;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       w = '0;
        1:       w = '1;
        2:       w = WINDOW_RESET;
        3:       w = WINDOW_W'($urandom_range(0, 65535));
        default: w = WINDOW_W'($urandom_range(0, 24));
      endcase
      write_window(w);
      // Every third phase is a burst with no idling; the others use random gaps.
      max_gap = (ph % 3 == 1) ? 0 : 18;
      pool_size = $urandom_range(3, 14);
      for (k = 0; k < pool_size; k++) pool[k] = page_t'($urandom);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        k = $urandom_range(0, pool_size - 1);
        if (roll < 8) begin
          send_reference(page_t'($urandom));
        end else begin
          if (roll < 12) pool[k] = page_t'($urandom);
          send_reference(pool[k]);
        end
      end
    end
    max_gap = 18;
  endtask

  // Check each strobed result against the oldest expectation.
  always @(posedge clk) begin
    ref_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result: hit=%0b frame=%0d ev=%0b evpage=%h hand=%0d",
                               out_hit, out_frame_index, out_evicted_valid,
                               out_evicted_page, out_hand_after));
      end else begin
        want = expected_results.pop_front();
        if (out_hit !== want.hit || out_frame_index !== want.frame_index ||
            out_evicted_valid !== want.evicted_valid ||
            out_evicted_page !== want.evicted_page ||
            out_hand_after !== want.hand_after) begin
          note_failure($sformatf({"page %h: expected hit=%0b frame=%0d ev=%0b evpage=%h ",
                                  "hand=%0d, got hit=%0b frame=%0d ev=%0b evpage=%h hand=%0d"},
                                 want.page, want.hit, want.frame_index, want.evicted_valid,
                                 want.evicted_page, want.hand_after, out_hit,
                                 out_frame_index, out_evicted_valid, out_evicted_page,
                                 out_hand_after));
        end
      end
    end
  end

  // Watchdog: reset the count on any transfer, give up after too long a silence.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_cold_fill();
    test_hits();
    test_full_circle();
    test_window_extremes();
    test_random_traffic();
    drain_results();
    // Leave room for a stray late strobe to show up.
    repeat (2 * FRAMES_DEF + 4) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
